### sv/lrfm_pkg.sv
`default_nettype none
package lrfm_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int MAX_FILES   = 64;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_AW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W  = 64;
  localparam int FILE_W = 6;
  localparam int ENT_W  = KEY_W + FILE_W + 1;

  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_LOOKUP = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_LOCK   = 3'd3;
  localparam logic [2:0] ACT_UNLOCK = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUP       = 3'd1;
  localparam logic [2:0] ST_LOCKED    = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_RANGE     = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CNT,
    S_EXEC,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic cnt_rd;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;

  function automatic logic [8:0] sat_count(input logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'd511) ? 9'd511 : w[8:0];
  endfunction

endpackage
`default_nettype wire

### sv/lrfm_ram.sv
`default_nettype none
module lrfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                                       clk_i,
  input  wire                                       we_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire [WIDTH-1:0]                           wdata_i,
  input  wire                                       re_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### sv/lrfm_ctrl.sv
`default_nettype none
module lrfm_ctrl (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  wire          out_stall_i,
  input  lrfm_pkg::sts_t sts_i,
  output lrfm_pkg::cmd_t cmd_o
);
  import lrfm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_SCAN;
      S_SCAN: if (sts_i.scan_done) state_d = S_CNT;
      S_CNT:  state_d = S_EXEC;
      S_EXEC: state_d = S_OUT;
      S_OUT:  if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_SCAN: cmd_o.scan = 1'b1;
      S_CNT:  cmd_o.cnt_rd = 1'b1;
      S_EXEC: cmd_o.exec = 1'b1;
      S_OUT:  out_valid_o = 1'b1;
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

### sv/lrfm_dp.sv
`default_nettype none
module lrfm_dp (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  lrfm_pkg::cmd_t cmd_i,
  output lrfm_pkg::sts_t sts_o,
  input  wire          cfg_we_i,
  input  wire [6:0]    cfg_wdata_i,
  input  wire [2:0]    action_i,
  input  wire [63:0]   record_id_i,
  input  wire [5:0]    file_id_i,
  input  wire          insert_locked_i,
  input  wire          lock_override_i,
  output logic [2:0]   status_o,
  output logic [5:0]   found_file_o,
  output logic         entry_locked_o,
  output logic [8:0]   file_count_o
);
  import lrfm_pkg::*;

  logic [6:0]             num_files_q;
  logic [2:0]             act_q;
  logic [KEY_W-1:0]       key_q;
  logic [FILE_W-1:0]      file_q;
  logic                   ins_lock_q, ovr_q;

  logic [TABLE_DEPTH-1:0] valid_q;
  logic [MAX_FILES-1:0]   cvalid_q;

  logic [IDX_W-1:0]       rd_idx_q, cmp_idx_q;
  logic                   issued_all_q, cmp_v_q;
  logic                   match_q, free_found_q;
  logic [IDX_W-1:0]       match_slot_q, free_slot_q;
  logic [FILE_W-1:0]      match_file_q;
  logic                   match_lock_q;

  logic [ENT_W-1:0]       tbl_rdata, tbl_wdata;
  logic                   tbl_we;
  logic [IDX_W-1:0]       tbl_waddr;
  logic [CNT_W-1:0]       cnt_rdata, cur_cnt, new_cnt;
  logic                   cnt_we;
  logic [CNT_AW-1:0]      cnt_addr;
  logic [31:0]            cnt_addr_w;
  logic                   hit, set_v, clr_v, in_range;
  logic [2:0]             st;
  logic [5:0]             ff;
  logic                   lk;
  logic [8:0]             fc;

  lrfm_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (cmd_i.scan),
    .raddr_i (rd_idx_q),
    .rdata_o (tbl_rdata)
  );

  lrfm_ram #(.WIDTH(CNT_W), .DEPTH(MAX_FILES)) u_cnt (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_addr),
    .wdata_i (new_cnt),
    .re_i    (cmd_i.cnt_rd),
    .raddr_i (cnt_addr),
    .rdata_o (cnt_rdata)
  );

  assign hit = cmp_v_q && valid_q[cmp_idx_q] &&
               (tbl_rdata[ENT_W-1 -: KEY_W] == key_q);
  assign sts_o.scan_done = cmp_v_q &&
                           (hit || (32'(cmp_idx_q) == TABLE_DEPTH - 1));

  assign cnt_addr_w = (act_q == ACT_INSERT) ? 32'(file_q) : 32'(match_file_q);
  assign cnt_addr   = cnt_addr_w[CNT_AW-1:0];
  assign cur_cnt    = cvalid_q[cnt_addr] ? cnt_rdata : '0;
  assign in_range   = ({1'b0, file_q} < num_files_q) &&
                      (32'(file_q) < MAX_FILES);

  always_comb begin
    st        = ST_NOT_FOUND;
    ff        = '0;
    lk        = 1'b0;
    fc        = '0;
    tbl_we    = 1'b0;
    tbl_waddr = match_slot_q;
    tbl_wdata = {key_q, match_file_q, match_lock_q};
    cnt_we    = 1'b0;
    new_cnt   = cur_cnt;
    set_v     = 1'b0;
    clr_v     = 1'b0;
    case (act_q)
      ACT_INSERT: begin
        if (match_q) begin
          st = ST_DUP;
        end else if (!in_range) begin
          st = ST_RANGE;
        end else if (!free_found_q) begin
          st = ST_FULL;
        end else begin
          st        = ST_OK;
          tbl_we    = 1'b1;
          tbl_waddr = free_slot_q;
          tbl_wdata = {key_q, file_q, ins_lock_q};
          set_v     = 1'b1;
          new_cnt   = cur_cnt + CNT_W'(1);
          cnt_we    = 1'b1;
          ff        = file_q;
          lk        = ins_lock_q;
          fc        = sat_count(new_cnt);
        end
      end
      ACT_LOOKUP, ACT_REMOVE: begin
        if (!match_q) begin
          st = ST_NOT_FOUND;
        end else if (match_lock_q && !ovr_q) begin
          st = ST_LOCKED;
          lk = 1'b1;
        end else begin
          st = ST_OK;
          if (act_q == ACT_REMOVE) begin
            clr_v  = 1'b1;
            cnt_we = 1'b1;
            if (cur_cnt != '0) new_cnt = cur_cnt - CNT_W'(1);
          end
          ff = match_file_q;
          lk = match_lock_q;
          fc = sat_count(new_cnt);
        end
      end
      ACT_LOCK, ACT_UNLOCK: begin
        if (match_q) begin
          st        = ST_OK;
          tbl_we    = 1'b1;
          tbl_wdata = {key_q, match_file_q, act_q == ACT_LOCK};
          ff        = match_file_q;
          lk        = (act_q == ACT_LOCK);
          fc        = sat_count(cur_cnt);
        end
      end
      default: st = ST_NOT_FOUND;
    endcase
    if (!cmd_i.exec) begin
      tbl_we = 1'b0;
      cnt_we = 1'b0;
      set_v  = 1'b0;
      clr_v  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_files_q  <= 7'd64;
      valid_q      <= '0;
      cvalid_q     <= '0;
      cmp_v_q      <= 1'b0;
      issued_all_q <= 1'b0;
      rd_idx_q     <= '0;
      match_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      if (cfg_we_i) num_files_q <= cfg_wdata_i;
      if (set_v) valid_q[free_slot_q] <= 1'b1;
      if (clr_v) valid_q[match_slot_q] <= 1'b0;
      if (cnt_we) cvalid_q[cnt_addr] <= 1'b1;
      if (cmd_i.load) begin
        rd_idx_q     <= '0;
        issued_all_q <= 1'b0;
        cmp_v_q      <= 1'b0;
        match_q      <= 1'b0;
        free_found_q <= 1'b0;
      end else if (cmd_i.scan) begin
        cmp_v_q <= !issued_all_q && !sts_o.scan_done;
        if (32'(rd_idx_q) == TABLE_DEPTH - 1) begin
          issued_all_q <= 1'b1;
        end else begin
          rd_idx_q <= rd_idx_q + IDX_W'(1);
        end
        if (hit) match_q <= 1'b1;
        if (cmp_v_q && !valid_q[cmp_idx_q] && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end else begin
        cmp_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q      <= action_i;
      key_q      <= record_id_i;
      file_q     <= file_id_i;
      ins_lock_q <= insert_locked_i;
      ovr_q      <= lock_override_i;
    end
    if (cmd_i.scan) begin
      cmp_idx_q <= rd_idx_q;
      if (hit) begin
        match_slot_q <= cmp_idx_q;
        match_file_q <= tbl_rdata[FILE_W:1];
        match_lock_q <= tbl_rdata[0];
      end
      if (cmp_v_q && !valid_q[cmp_idx_q] && !free_found_q) begin
        free_slot_q <= cmp_idx_q;
      end
    end
    if (cmd_i.exec) begin
      status_o       <= st;
      found_file_o   <= ff;
      entry_locked_o <= lk;
      file_count_o   <= fc;
    end
  end

endmodule
`default_nettype wire

### sv/locked_record_file_map.sv
// Locked record file map: a 256-slot table keyed by a 64-bit record id that
// holds a file number and a lock mark per entry, plus an entry count per file.
// Each input transaction (insert, lookup, remove, lock, unlock) yields exactly
// one result transaction. Items are handled one at a time: an item scans the
// table memory from slot 0 with one slot read per cycle, stopping at the first
// key match, then reads the per-file count memory and, for an insert or a
// remove that succeeds, updates it. The sequencer steps through S_SCAN, S_CNT,
// S_EXEC and S_OUT in that order and takes no new input until the result has
// been taken; a scan with no key match reads every slot, and the result waits
// while the output is stalled. The slot-by-slot scan of the table memory, one
// read per cycle, is the long part of each item. Reset clears the valid bits
// of the table and of the counts, so the block is usable right away.
// The num_files register may be written only while the block is idle.
`default_nettype none
module locked_record_file_map (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire [6:0]  cfg_wdata_i,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire [2:0]  action_i,
  input  wire [63:0] record_id_i,
  input  wire [5:0]  file_id_i,
  input  wire        insert_locked_i,
  input  wire        lock_override_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [2:0] status_o,
  output logic [5:0] found_file_o,
  output logic       entry_locked_o,
  output logic [8:0] file_count_o
);
  import lrfm_pkg::*;

  // Commands from the sequencer and the scan status back to it.
  cmd_t cmd;
  sts_t sts;

  lrfm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lrfm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .action_i        (action_i),
    .record_id_i     (record_id_i),
    .file_id_i       (file_id_i),
    .insert_locked_i (insert_locked_i),
    .lock_override_i (lock_override_i),
    .status_o        (status_o),
    .found_file_o    (found_file_o),
    .entry_locked_o  (entry_locked_o),
    .file_count_o    (file_count_o)
  );

endmodule
`default_nettype wire

### sv/lrfm_checker.sv
`default_nettype none
module lrfm_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_stall_o,
  input wire       out_valid_o,
  input wire       out_stall_i,
  input wire [2:0] status_o,
  input wire [5:0] found_file_o,
  input wire       entry_locked_o,
  input wire [8:0] file_count_o
);
  import lrfm_pkg::*;

  // An error result carries no file number and no count.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (found_file_o == 6'd0) && (file_count_o == 9'd0))
    else $error("error result carries data");

  // On an error result the lock mark is set only for a locked entry.
  a_err_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> entry_locked_o == (status_o == ST_LOCKED))
    else $error("lock mark wrong on error result");

  // An accepted item keeps the input side busy in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // One result per item: a delivered result is not followed at once by another.
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("extra result");

endmodule

bind locked_record_file_map lrfm_checker u_lrfm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .found_file_o   (found_file_o),
  .entry_locked_o (entry_locked_o),
  .file_count_o   (file_count_o)
);
`default_nettype wire

### verif/locked_record_file_map_tb.sv
`default_nettype none
module locked_record_file_map_tb;
  import lrfm_pkg::*;

  // One transaction offered to the block.
  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] record_id;
    logic [5:0]  file_id;
    logic        insert_locked;
    logic        lock_override;
  } request_t;

  // One result transaction expected from the block.
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] found_file;
    logic       entry_locked;
    logic [8:0] file_count;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = 7'd0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  action_i = 3'd0;
  logic [63:0] record_id_i = 64'd0;
  logic [5:0]  file_id_i = 6'd0;
  logic        insert_locked_i = 1'b0;
  logic        lock_override_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [5:0]  found_file_o;
  logic        entry_locked_o;
  logic [8:0]  file_count_o;

  locked_record_file_map uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .action_i(action_i), .record_id_i(record_id_i), .file_id_i(file_id_i),
    .insert_locked_i(insert_locked_i), .lock_override_i(lock_override_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .status_o(status_o), .found_file_o(found_file_o),
    .entry_locked_o(entry_locked_o), .file_count_o(file_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the table, the per-file counts and the num_files register.
  logic        shadow_valid [TABLE_DEPTH] = '{default: 1'b0};
  logic [63:0] shadow_key   [TABLE_DEPTH];
  logic [5:0]  shadow_file  [TABLE_DEPTH];
  logic        shadow_lock  [TABLE_DEPTH];
  int unsigned shadow_count [MAX_FILES] = '{default: 0};
  logic [6:0]  shadow_num_files = 7'd64;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int       mismatches = 0;
  int       answers_seen = 0;
  int       requests_sent = 0;
  int       status_hits[8] = '{default: 0};
  bit       hold_receiver = 1'b0;   // asks the receiver process for a long stall

  // Ids live in a small pool most of the time, so that duplicates,
  // removals and lock changes hit stored entries often.
  logic [63:0] id_pool[48];

  function automatic logic [8:0] clamp_count(input int unsigned c);
    return (c > 511) ? 9'd511 : c[8:0];
  endfunction

  // Applies one transaction to the shadow state and returns its answer.
  function automatic answer_t apply_request(input request_t r);
    answer_t     a;
    int          hit;
    int          hole;
    int unsigned lim;
    logic [5:0]  f;
    a = '0;
    hit = -1;
    hole = -1;
    lim = (shadow_num_files > MAX_FILES) ? MAX_FILES : shadow_num_files;
    if (r.action > ACT_UNLOCK) begin
      a.status = ST_NOT_FOUND;
      return a;
    end
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (hit < 0 && shadow_valid[i] && shadow_key[i] == r.record_id) hit = i;
    if (r.action == ACT_INSERT) begin
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (hole < 0 && !shadow_valid[i]) hole = i;
      if (hit >= 0) a.status = ST_DUP;
      else if (r.file_id >= lim) a.status = ST_RANGE;
      else if (hole < 0) a.status = ST_FULL;
      else begin
        shadow_valid[hole] = 1'b1;
        shadow_key[hole] = r.record_id;
        shadow_file[hole] = r.file_id;
        shadow_lock[hole] = r.insert_locked;
        shadow_count[r.file_id]++;
        a.status = ST_OK;
        a.found_file = r.file_id;
        a.entry_locked = r.insert_locked;
        a.file_count = clamp_count(shadow_count[r.file_id]);
      end
      return a;
    end
    if (hit < 0) begin
      a.status = ST_NOT_FOUND;
      return a;
    end
    f = shadow_file[hit];
    if (r.action == ACT_LOOKUP || r.action == ACT_REMOVE) begin
      if (shadow_lock[hit] && !r.lock_override) begin
        a.status = ST_LOCKED;
        a.entry_locked = 1'b1;
        return a;
      end
      if (r.action == ACT_REMOVE) begin
        shadow_valid[hit] = 1'b0;
        if (shadow_count[f] > 0) shadow_count[f]--;
      end
    end else begin
      shadow_lock[hit] = (r.action == ACT_LOCK);
    end
    a.status = ST_OK;
    a.found_file = f;
    a.entry_locked = shadow_lock[hit];
    a.file_count = clamp_count(shadow_count[f]);
    return a;
  endfunction

  function automatic request_t make_request(input logic [2:0] act, input logic [63:0] id,
                                            input logic [5:0] f, input logic lk,
                                            input logic ovr);
    request_t r;
    r.action = act;
    r.record_id = id;
    r.file_id = f;
    r.insert_locked = lk;
    r.lock_override = ovr;
    return r;
  endfunction

  // Appends one transaction to the driver's queue.
  function automatic void enqueue(input request_t r);
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  // Random transaction; mostly legal actions on pool ids, plus full-range noise.
  function automatic request_t random_request(input int file_span);
    request_t r;
    int       pick;
    r.record_id = ($urandom_range(9, 0) == 0) ? {$urandom, $urandom}
                                               : id_pool[$urandom_range(47, 0)];
    pick = $urandom_range(99, 0);
    if (pick < 38) r.action = ACT_INSERT;
    else if (pick < 55) r.action = ACT_LOOKUP;
    else if (pick < 75) r.action = ACT_REMOVE;
    else if (pick < 86) r.action = ACT_LOCK;
    else if (pick < 97) r.action = ACT_UNLOCK;
    else r.action = 3'($urandom_range(7, 5));
    r.file_id = ($urandom_range(7, 0) == 0) ? 6'($urandom) : 6'($urandom_range(file_span, 0));
    r.insert_locked = $urandom_range(2, 0) == 0;
    r.lock_override = 1'($urandom_range(1, 0));
    return r;
  endfunction

  // Gap length on either side: mostly none or short, now and then long.
  function automatic int gap_length();
    int p;
    p = $urandom_range(99, 0);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Driver: offers queued transactions, holds the payload while stalled.
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        requests_sent <= requests_sent + 1;
        expected_answers.insert(expected_answers.size(),
                                apply_request(pending_requests.pop_front()));
      end
      if (in_valid_i && in_stall_o) begin
        // Payload stays put until the block takes it.
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if ((in_valid_i && !in_stall_o ? pending_requests.size() > 0
                                               : pending_requests.size() > 0)) begin
        in_valid_i <= 1'b1;
        action_i <= pending_requests[0].action;
        record_id_i <= pending_requests[0].record_id;
        file_id_i <= pending_requests[0].file_id;
        insert_locked_i <= pending_requests[0].insert_locked;
        lock_override_i <= pending_requests[0].lock_override;
        send_gap <= gap_length();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (hold_receiver) begin
        stall_left <= 3000;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(3, 0) == 0) begin
        stall_left <= gap_length();
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: compares each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    answer_t seen;
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = {status_o, found_file_o, entry_locked_o, file_count_o};
      answers_seen <= answers_seen + 1;
      if (expected_answers.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", seen);
      end else begin
        want = expected_answers.pop_front();
        status_hits[want.status] <= status_hits[want.status] + 1;
        if (seen !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("result %0d mismatch: expected %p, got %p", answers_seen, want, seen);
        end
      end
    end
  end

  task automatic drain_and_settle();
    wait (pending_requests.size() == 0 && !in_valid_i);
    wait (expected_answers.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_num_files(input logic [6:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_num_files = value;
  endtask

  task automatic queue_random(input int n, input int file_span);
    for (int i = 0; i < n; i++) enqueue(random_request(file_span));
  endtask

  initial begin
    logic [6:0] settings[6];
    for (int i = 0; i < 48; i++) id_pool[i] = {$urandom, $urandom};
    id_pool[0] = 64'd0;
    id_pool[1] = '1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset value of num_files: field extremes, each action,
    // a duplicate, lock refusal and override, unlock, remove, undefined codes.
    enqueue(make_request(ACT_INSERT, 64'd0, 6'd0, 1'b0, 1'b0));
    enqueue(make_request(ACT_INSERT, '1, 6'd63, 1'b1, 1'b1));
    enqueue(make_request(ACT_INSERT, '1, 6'd5, 1'b0, 1'b0));
    enqueue(make_request(ACT_LOOKUP, '1, 6'd0, 1'b0, 1'b0));
    enqueue(make_request(ACT_LOOKUP, '1, 6'd0, 1'b0, 1'b1));
    enqueue(make_request(ACT_REMOVE, '1, 6'd0, 1'b0, 1'b0));
    enqueue(make_request(ACT_UNLOCK, '1, 6'd0, 1'b0, 1'b0));
    enqueue(make_request(ACT_LOCK, 64'd0, 6'd0, 1'b0, 1'b0));
    enqueue(make_request(ACT_LOCK, 64'd0, 6'd0, 1'b0, 1'b0));
    enqueue(make_request(ACT_REMOVE, 64'd0, 6'd0, 1'b0, 1'b1));
    enqueue(make_request(ACT_REMOVE, '1, 6'd0, 1'b0, 1'b0));
    enqueue(make_request(ACT_LOOKUP, '1, 6'd0, 1'b0, 1'b0));
    enqueue(make_request(3'd5, 64'd0, 6'd0, 1'b0, 1'b0));
    enqueue(make_request(3'd7, '1, 6'd63, 1'b1, 1'b1));
    enqueue(make_request(ACT_UNLOCK, 64'h5555_aaaa_0f0f_f0f0, 6'd1, 1'b0, 1'b0));
    drain_and_settle();

    // A narrow file range, a zero count that accepts nothing, and a value above
    // the file limit, each tested against inserts around the boundary.
    write_num_files(7'd1);
    enqueue(make_request(ACT_INSERT, 64'd10, 6'd1, 1'b0, 1'b0));
    enqueue(make_request(ACT_INSERT, 64'd11, 6'd0, 1'b0, 1'b0));
    queue_random(120, 2);
    drain_and_settle();
    write_num_files(7'd0);
    enqueue(make_request(ACT_INSERT, 64'd12, 6'd0, 1'b0, 1'b0));
    queue_random(40, 63);
    drain_and_settle();
    write_num_files(7'd127);
    enqueue(make_request(ACT_INSERT, 64'd13, 6'd63, 1'b0, 1'b0));
    drain_and_settle();

    // Fill the table: every slot taken, then full-table refusals, then the
    // receiver holds off for a long stretch while the sender keeps offering.
    for (int i = 0; i < TABLE_DEPTH; i++)
      enqueue(make_request(ACT_INSERT, 64'h1000_0000 + i,
                           6'($urandom_range(3, 0)), 1'b0, 1'b0));
    enqueue(make_request(ACT_INSERT, 64'hdead_beef, 6'd2, 1'b0, 1'b0));
    hold_receiver = 1'b1;
    @(posedge clk_i);
    @(posedge clk_i);
    hold_receiver = 1'b0;
    for (int i = 0; i < 40; i++)
      enqueue(make_request(ACT_REMOVE, 64'h1000_0000 + i * 3, 6'd0, 1'b0, 1'b1));
    drain_and_settle();
    // Remove the fill entries again so the random phases start from light occupancy.
    for (int i = 0; i < TABLE_DEPTH; i++)
      enqueue(make_request(ACT_REMOVE, 64'h1000_0000 + i, 6'd0, 1'b0, 1'b1));
    drain_and_settle();

    // Random phases across several register settings.
    settings = '{7'd64, 7'd3, 7'd17, 7'd63, 7'd100, 7'd8};
    foreach (settings[k]) begin
      write_num_files(settings[k]);
      queue_random(36, (settings[k] > 63) ? 63 : settings[k]);
      drain_and_settle();
    end

    $display("Ran %0d transactions over several num_files settings including 0, 1 and 127,",
             requests_sent);
    $display("with ok %0d, duplicate %0d, locked %0d, not found %0d, full %0d, range %0d.",
             status_hits[ST_OK], status_hits[ST_DUP], status_hits[ST_LOCKED],
             status_hits[ST_NOT_FOUND], status_hits[ST_FULL], status_hits[ST_RANGE]);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("locked_record_file_map_tb: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("locked_record_file_map_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: about 950 transactions with gaps and
  // stalls, plus one long hold-off, come to well under a sixth of this.
  initial begin
    #4000000;
    $display("timeout after %0d results", answers_seen);
    $display("locked_record_file_map_tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
